// ===== src/tlpt_pkg.sv =====
// Shared types and constants of the two-level page table engine.
`timescale 1ns / 1ps
`default_nettype none
package tlpt_pkg;

  // Fixed geometry of a 4 KiB page and a 32-bit entry.
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned VPN_W      = 20;
  localparam int unsigned CNT_W      = 21;
  localparam int unsigned ENTRY_W    = 32;

  // Request type codes.
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_MAP    = 2'd1;
  localparam logic [1:0] REQ_FILL   = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INVAL = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // One incoming request.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [31:0] phys_limit;
    logic [11:0] flags;
  } in_req_t;

  // One result.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] entry_value;
    logic [20:0] pages_done;
  } out_rsp_t;

  // What the front hands to the back.
  typedef enum logic [1:0] {
    CMD_IMMED,
    CMD_LOOKUP,
    CMD_WALK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [1:0]       status;
    logic [VPN_W-1:0] vpn;
    logic [VPN_W-1:0] ppn;
    logic [CNT_W-1:0] pages;
    logic [11:0]      flags;
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_WALK,
    BK_REPLY
  } back_state_t;

endpackage
`default_nettype wire

// ===== src/two_level_page_table_engine_top.sv =====
// A lookup passes from the queue through BK_IDLE, BK_READ and BK_REPLY; a request rejected
// on classification goes from BK_IDLE straight to BK_REPLY.
// A range map writes one page at a time in BK_WALK, as the store has a single port.
// An identity fill walks all DIR_ENTRIES * TABLE_ENTRIES entries in BK_WALK.
// Flow: one request at a time in the back end; a two-entry queue lets requests wait,
// and an unread result holds the back end. Reset clears queues and sequencer, not the store.
`timescale 1ns / 1ps
`default_nettype none
module two_level_page_table_engine_top
  import tlpt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned DIR_ENTRIES   = 64
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  output logic         full,
  input  wire in_req_t in_data,
  output logic         empty,
  input  wire logic    pop,
  output out_rsp_t     out_data
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // Request classification and command queue.
  tlpt_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .DIR_ENTRIES  (DIR_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  // Store access sequencer and result register.
  tlpt_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .DIR_ENTRIES  (DIR_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ===== src/tlpt_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tlpt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One access per cycle: a write or a read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end else if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== src/tlpt_front.sv =====
// Front end: takes requests, classifies them and queues commands for the back end.
`timescale 1ns / 1ps
`default_nettype none
module tlpt_front
  import tlpt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned DIR_ENTRIES   = 64
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  output logic         full,
  input  wire in_req_t in_data,
  output logic         cmd_valid,
  output cmd_t         cmd,
  input  wire logic    cmd_pop
);

  localparam int unsigned     STORE_SIZE = DIR_ENTRIES * TABLE_ENTRIES;
  localparam logic [CNT_W-1:0] STORE_LIM = CNT_W'(STORE_SIZE);

  logic             accept;
  cmd_t             cmd_new;
  logic [VPN_W-1:0] vpn;
  logic [VPN_W-1:0] ppn;
  logic [VPN_W-1:0] pend_pn;
  logic             misaligned;
  logic             reversed;

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_nxt;

  assign full   = (cnt_r == 2'd2);
  assign accept = push && !full;

  assign vpn     = in_data.virt_addr[31:PAGE_SHIFT];
  assign ppn     = in_data.phys_addr[31:PAGE_SHIFT];
  assign pend_pn = in_data.phys_limit[31:PAGE_SHIFT];

  assign misaligned = (in_data.virt_addr[PAGE_SHIFT-1:0] != '0) ||
                      (in_data.phys_addr[PAGE_SHIFT-1:0] != '0) ||
                      (in_data.phys_limit[PAGE_SHIFT-1:0] != '0);
  assign reversed   = (in_data.phys_limit < in_data.phys_addr);

  // Classify the request. The flat store index is the virtual page number,
  // and it lies in the store exactly when it is below the store size.
  always_comb begin
    cmd_new        = '0;
    cmd_new.kind   = CMD_IMMED;
    cmd_new.status = ST_INVAL;
    cmd_new.flags  = in_data.flags;
    unique case (in_data.req_type)
      REQ_LOOKUP: begin
        cmd_new.vpn = vpn;
        if ({1'b0, vpn} < STORE_LIM) begin
          cmd_new.kind   = CMD_LOOKUP;
          cmd_new.status = ST_OK;
        end else begin
          cmd_new.status = ST_RANGE;
        end
      end
      REQ_MAP: begin
        if (!misaligned && !reversed) begin
          cmd_new.kind   = CMD_WALK;
          cmd_new.status = ST_OK;
          cmd_new.vpn    = vpn;
          cmd_new.ppn    = ppn;
          cmd_new.pages  = {1'b0, pend_pn - ppn};
        end
      end
      REQ_FILL: begin
        // An identity fill is a walk from page zero over the whole store.
        cmd_new.kind   = CMD_WALK;
        cmd_new.status = ST_OK;
        cmd_new.pages  = STORE_LIM;
      end
      default: begin
        cmd_new.kind = CMD_IMMED;
      end
    endcase
  end

  // Two-entry command queue between front and back.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (accept) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (cmd_pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (accept && !cmd_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!accept && cmd_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= cmd_new;
    end
  end

  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

endmodule
`default_nettype wire

// ===== src/tlpt_back.sv =====
// Back end: sequencer that reads and writes the entry store and returns results.
`timescale 1ns / 1ps
`default_nettype none
module tlpt_back
  import tlpt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned DIR_ENTRIES   = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  output logic      empty,
  input  wire logic pop,
  output out_rsp_t  out_data
);

  localparam int unsigned      STORE_SIZE = DIR_ENTRIES * TABLE_ENTRIES;
  localparam int unsigned      AW         = $clog2(STORE_SIZE);
  localparam logic [CNT_W-1:0] STORE_LIM  = CNT_W'(STORE_SIZE);

  back_state_t      state_r, state_nxt;
  logic [VPN_W-1:0] vpn_r, vpn_nxt;
  logic [VPN_W-1:0] ppn_r, ppn_nxt;
  logic [11:0]      flags_r, flags_nxt;
  logic [CNT_W-1:0] pages_r, pages_nxt;
  logic [CNT_W-1:0] done_r, done_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [31:0]      value_r, value_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_rsp_t         out_rsp_r, out_rsp_nxt;

  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_addr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  tlpt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(STORE_SIZE)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Lookups address the store straight from the queue head; walks from the page counter.
  assign ram_addr  = (state_r == BK_IDLE) ? cmd.vpn[AW-1:0] : vpn_r[AW-1:0];
  assign ram_wdata = {ppn_r, flags_r};

  // Sequencer: next state, store control and result assembly.
  always_comb begin
    state_nxt     = state_r;
    vpn_nxt       = vpn_r;
    ppn_nxt       = ppn_r;
    flags_nxt     = flags_r;
    pages_nxt     = pages_r;
    done_nxt      = done_r;
    status_nxt    = status_r;
    value_nxt     = value_r;
    out_valid_nxt = out_valid_r && !pop;
    out_rsp_nxt   = out_rsp_r;
    cmd_pop       = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          vpn_nxt    = cmd.vpn;
          ppn_nxt    = cmd.ppn;
          flags_nxt  = cmd.flags;
          pages_nxt  = cmd.pages;
          done_nxt   = '0;
          status_nxt = cmd.status;
          value_nxt  = '0;
          unique case (cmd.kind)
            CMD_LOOKUP: begin
              ram_re    = 1'b1;
              state_nxt = BK_READ;
            end
            CMD_WALK: state_nxt = BK_WALK;
            default:  state_nxt = BK_REPLY;
          endcase
        end
      end
      BK_READ: begin
        value_nxt = ram_rdata;
        state_nxt = BK_REPLY;
      end
      BK_WALK: begin
        // One entry per cycle until the count is reached or the store ends.
        if (done_r == pages_r) begin
          state_nxt = BK_REPLY;
        end else if ({1'b0, vpn_r} >= STORE_LIM) begin
          status_nxt = ST_RANGE;
          state_nxt  = BK_REPLY;
        end else begin
          ram_we   = 1'b1;
          vpn_nxt  = vpn_r + VPN_W'(1);
          ppn_nxt  = ppn_r + VPN_W'(1);
          done_nxt = done_r + CNT_W'(1);
        end
      end
      BK_REPLY: begin
        if (!out_valid_r || pop) begin
          out_valid_nxt           = 1'b1;
          out_rsp_nxt.status      = status_r;
          out_rsp_nxt.entry_value = value_r;
          out_rsp_nxt.pages_done  = done_r;
          state_nxt               = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vpn_r     <= vpn_nxt;
    ppn_r     <= ppn_nxt;
    flags_r   <= flags_nxt;
    pages_r   <= pages_nxt;
    done_r    <= done_nxt;
    status_r  <= status_nxt;
    value_r   <= value_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign empty    = !out_valid_r;
  assign out_data = out_rsp_r;

endmodule
`default_nettype wire

// ===== tb/page_table_checker.sv =====
// Checker that predicts and compares every result of the page table engine.
`timescale 1ns / 1ps
module page_table_checker
  import tlpt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned DIR_ENTRIES   = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  logic     full,
  input  in_req_t  in_data,
  input  logic     empty,
  input  logic     pop,
  input  out_rsp_t out_data,
  output int       mismatches,
  output int       outstanding
);

  localparam int unsigned PAGE_BYTES    = 1 << PAGE_SHIFT;
  localparam int unsigned STORE_ENTRIES = TABLE_ENTRIES * DIR_ENTRIES;
  localparam logic [31:0] ADDR_MASK     = 32'hFFFF_F000;
  localparam logic [31:0] OFFSET_MASK   = 32'h0000_0FFF;

  // Shadow copy of the entry store and of the walk counter.
  logic [31:0]      shadow_entries [STORE_ENTRIES];
  logic [CNT_W-1:0] walk_count = '0;

  // Results still owed by the engine, oldest first.
  out_rsp_t replies_due [$];
  out_rsp_t oldest;
  int       error_count = 0;
  int       due_count   = 0;

  assign mismatches  = error_count;
  assign outstanding = due_count;

  // Splits a virtual address into a flat store index; false beyond the store.
  function automatic bit page_index(input logic [31:0] vaddr, output int unsigned idx);
    longint unsigned span;
    longint unsigned dir;
    longint unsigned tab;
    span = longint'(TABLE_ENTRIES) * PAGE_BYTES;
    dir  = vaddr / span;
    tab  = (vaddr % span) / PAGE_BYTES;
    idx  = 0;
    if (dir >= DIR_ENTRIES) return 1'b0;
    idx = int'(dir * TABLE_ENTRIES + tab);
    return 1'b1;
  endfunction

  // Applies one request to the shadow store and returns the result it owes.
  function automatic out_rsp_t resolve_request(input in_req_t req);
    out_rsp_t    rsp;
    logic [31:0] vaddr;
    logic [31:0] paddr;
    int unsigned idx;
    int unsigned pages;
    int unsigned written;
    rsp.status      = ST_OK;
    rsp.entry_value = '0;
    rsp.pages_done  = '0;
    written         = 0;
    case (req.req_type)
      REQ_LOOKUP: begin
        if (page_index(req.virt_addr, idx)) rsp.entry_value = shadow_entries[idx];
        else rsp.status = ST_RANGE;
      end
      REQ_MAP: begin
        if ((req.virt_addr & OFFSET_MASK) != 0 || (req.phys_addr & OFFSET_MASK) != 0 ||
            (req.phys_limit & OFFSET_MASK) != 0 || req.phys_limit < req.phys_addr) begin
          rsp.status = ST_INVAL;
        end else begin
          pages = (req.phys_limit - req.phys_addr) >> PAGE_SHIFT;
          vaddr = req.virt_addr;
          paddr = req.phys_addr;
          // Walk page by page; the first page beyond the store stops the walk.
          while (written < pages && rsp.status == ST_OK) begin
            if (!page_index(vaddr, idx)) begin
              rsp.status = ST_RANGE;
            end else begin
              shadow_entries[idx] = (paddr & ADDR_MASK) | 32'(req.flags);
              written++;
              vaddr += PAGE_BYTES;
              paddr += PAGE_BYTES;
            end
          end
        end
      end
      REQ_FILL: begin
        for (int unsigned n = 0; n < STORE_ENTRIES; n++) begin
          shadow_entries[n] = ((32'(n) << PAGE_SHIFT) & ADDR_MASK) | 32'(req.flags);
        end
        written = STORE_ENTRIES;
      end
      default: begin
        rsp.status = ST_INVAL;
      end
    endcase
    walk_count     = written[CNT_W-1:0];
    rsp.pages_done = walk_count;
    return rsp;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("checker: %s mismatch at %0t: got 0x%0h, expected 0x%0h",
             what, $realtime, got, want);
    error_count++;
  endtask

  // Predict on every accepted request, compare on every accepted result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) replies_due.push_back(resolve_request(in_data));
      if (pop && !empty) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unrequested result", 32'(out_data.status), 32'(ST_OK));
        end else begin
          oldest = replies_due.pop_front();
          if (out_data.status !== oldest.status)
            report_mismatch("status", 32'(out_data.status), 32'(oldest.status));
          if (out_data.entry_value !== oldest.entry_value)
            report_mismatch("entry_value", out_data.entry_value, oldest.entry_value);
          if (out_data.pages_done !== oldest.pages_done)
            report_mismatch("pages_done", 32'(out_data.pages_done), 32'(oldest.pages_done));
        end
      end
      due_count = replies_due.size();
    end
  end

endmodule

// ===== tb/two_level_page_table_engine_top_tb.sv =====
// Stimulus and verdict for the two-level page table engine.
`timescale 1ns / 1ps
module two_level_page_table_engine_top_tb;
  import tlpt_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned DIR_ENTRIES   = 64;
  localparam int unsigned STORE_PAGES   = TABLE_ENTRIES * DIR_ENTRIES;
  localparam int unsigned PAGE_BYTES    = 1 << PAGE_SHIFT;
  localparam logic [1:0]  REQ_UNKNOWN   = 2'd3;
  localparam int unsigned RANDOM_REQS   = 1200;
  localparam int unsigned MAX_FILLS     = 2;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        push    = 1'b0;
  logic        pop     = 1'b0;
  in_req_t     in_data = '0;
  logic        full;
  logic        empty;
  out_rsp_t    out_data;
  int          mismatches;
  int          outstanding;
  int unsigned cycle_count   = 0;
  int          push_calm     = 0;
  int          pop_calm      = 0;
  logic [31:0] last_map_virt = '0;

  two_level_page_table_engine_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .DIR_ENTRIES  (DIR_ENTRIES)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

  page_table_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .DIR_ENTRIES  (DIR_ENTRIES)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_data    (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data   (out_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // Free-running clock.
  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Draws the idle cycles before the next handshake, with stretches of none.
  function automatic int pick_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      calm = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  function automatic in_req_t make_req(input logic [1:0] kind, input logic [31:0] vaddr,
                                       input logic [31:0] paddr, input logic [31:0] pend,
                                       input logic [11:0] flg);
    in_req_t req;
    req.req_type   = kind;
    req.virt_addr  = vaddr;
    req.phys_addr  = paddr;
    req.phys_limit = pend;
    req.flags      = flg;
    return req;
  endfunction

  // An aligned range map: mostly a few pages, now and then a long run or one near the end.
  function automatic in_req_t plan_map();
    logic [31:0] vpage;
    logic [31:0] base;
    int unsigned pages;
    if ($urandom_range(0, 9) == 0) vpage = STORE_PAGES - $urandom_range(1, 8);
    else vpage = $urandom_range(0, STORE_PAGES - 1);
    if ($urandom_range(0, 49) == 0) pages = $urandom_range(17, 4096);
    else pages = $urandom_range(0, 16);
    base = $urandom & 32'hFFFF_F000;
    return make_req(REQ_MAP, vpage << PAGE_SHIFT, base, base + pages * PAGE_BYTES,
                    12'($urandom));
  endfunction

  // Offers one request; push stays high when the next one follows at once.
  task automatic send_request(input in_req_t req);
    int gap;
    gap = pick_gap(push_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= req;
    push    <= 1'b1;
    do @(posedge clk); while (full);
  endtask

  // Result side: random stalls before each pop.
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      gap = pick_gap(pop_calm);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // Request side: reset, directed requests, random requests, then the verdict.
  initial begin
    in_req_t     req;
    int unsigned pick;
    int unsigned fills_done;
    fills_done = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Only lookups beyond the store are safe before the first fill.
    send_request(make_req(REQ_LOOKUP, 32'h1000_0000, '0, '0, '0));
    send_request(make_req(REQ_LOOKUP, 32'hFFFF_FFFF, '1, '1, '1));
    send_request(make_req(REQ_UNKNOWN, '1, '1, '1, '1));
    // Misaligned and reversed maps write nothing.
    send_request(make_req(REQ_MAP, 32'h0000_0001, 32'h0000_1000, 32'h0000_3000, 12'h111));
    send_request(make_req(REQ_MAP, 32'h0000_1000, 32'h0000_1800, 32'h0000_3000, 12'h222));
    send_request(make_req(REQ_MAP, 32'h0000_1000, 32'h0000_1000, 32'h0000_3FFF, 12'h333));
    send_request(make_req(REQ_MAP, 32'h0000_1000, 32'h0000_2000, 32'h0000_1000, 12'h444));
    // A map that starts beyond the store fails at once.
    send_request(make_req(REQ_MAP, 32'h1000_0000, 32'h0000_0000, 32'h0000_1000, 12'h555));
    send_request(make_req(REQ_FILL, '0, '0, '0, 12'hFFF));
    send_request(make_req(REQ_LOOKUP, 32'h0000_0000, '0, '0, '0));
    send_request(make_req(REQ_LOOKUP, 32'h0FFF_FFFF, '0, '0, '0));
    send_request(make_req(REQ_FILL, '1, '1, '1, 12'h000));
    // Empty range, then a range that runs off the end of the store.
    send_request(make_req(REQ_MAP, 32'h0010_0000, 32'hFFFF_F000, 32'hFFFF_F000, 12'h0F0));
    send_request(make_req(REQ_MAP, 32'h0FFF_E000, 32'hFFFF_C000, 32'hFFFF_F000, 12'hA5A));
    send_request(make_req(REQ_LOOKUP, 32'h0FFF_E123, '0, '0, '0));
    send_request(make_req(REQ_LOOKUP, 32'h0FFF_F000, '0, '0, '0));
    // Virtual page at the top of the address space.
    send_request(make_req(REQ_MAP, 32'hFFFF_F000, 32'h0000_0000, 32'h0000_2000, 12'h5A5));
    // Widest physical range: the walk stops at the end of the store.
    send_request(make_req(REQ_MAP, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_F000, 12'h123));
    send_request(make_req(REQ_LOOKUP, 32'h0000_0FFF, '0, '0, '0));
    send_request(make_req(REQ_LOOKUP, 32'h0123_4567, '0, '0, '0));
    send_request(make_req(REQ_MAP, 32'h0010_0000, 32'h8000_0000, 32'h8000_4000, 12'h001));
    send_request(make_req(REQ_LOOKUP, 32'h0010_3000, '0, '0, '0));
    last_map_virt = 32'h0010_0000;

    // Random mix; every entry has been written by now, so any lookup is legal.
    for (int i = 0; i < RANDOM_REQS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick == 99 && fills_done < MAX_FILLS) begin
        req = make_req(REQ_FILL, $urandom, $urandom, $urandom, 12'($urandom));
        fills_done++;
      end else if (pick < 45 || pick == 99) begin
        case ($urandom_range(0, 9))
          0:       req = make_req(REQ_LOOKUP, $urandom, $urandom, $urandom, 12'($urandom));
          1:       req = make_req(REQ_LOOKUP, $urandom_range(0, STORE_PAGES * PAGE_BYTES - 1),
                                  '0, '0, '0);
          default: req = make_req(REQ_LOOKUP,
                                  last_map_virt + $urandom_range(0, 8 * PAGE_BYTES - 1),
                                  '0, '0, '0);
        endcase
      end else if (pick < 85) begin
        req = plan_map();
        last_map_virt = req.virt_addr;
      end else if (pick < 95) begin
        // Broken maps: one field misaligned, a reversed range, or pure noise.
        req = plan_map();
        case ($urandom_range(0, 4))
          0: req.virt_addr[11:0]  = 12'($urandom_range(1, 4095));
          1: req.phys_addr[11:0]  = 12'($urandom_range(1, 4095));
          2: req.phys_limit[11:0] = 12'($urandom_range(1, 4095));
          3: begin
            req.phys_addr  = req.phys_addr | 32'h8000_0000;
            req.phys_limit = req.phys_addr - $urandom_range(1, 16) * PAGE_BYTES;
          end
          default: req = make_req(REQ_MAP, $urandom, $urandom, $urandom, 12'($urandom));
        endcase
      end else begin
        req = make_req(REQ_UNKNOWN, $urandom, $urandom, $urandom, 12'($urandom));
      end
      send_request(req);
    end

    // Drain: wait for every result, then keep running to catch stray ones.
    push <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (32) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
